// ===== rtl/tdt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdt_pkg
// Shared types and constants for the tag de-duplication table with aging.
// ----------------------------------------------------------------------------
package tdt_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 16;
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam int unsigned TIMEOUT_W       = 29;
  localparam int unsigned LIMIT_W         = 33;
  localparam int unsigned SWEEP_FACTOR    = 10;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 29'd1000;

  localparam logic CMD_OBSERVE = 1'b0;
  localparam logic CMD_SWEEP   = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [31:0] epc_high;
    logic [63:0] epc_low;
    logic [31:0] now_ms;
  } in_word_t;

  typedef struct packed {
    logic       report;
    logic       table_full;
    logic [4:0] removed_count;
    logic [4:0] occupancy;
  } out_word_t;

  // classified work handed from the front to the table engine
  typedef struct packed {
    logic                 sweep;
    logic [31:0]          key_high;
    logic [63:0]          key_low;
    logic [31:0]          now;
    logic [TIMEOUT_W-1:0] timeout;
    logic [LIMIT_W-1:0]   limit;
  } task_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage : tdt_pkg
`default_nettype wire

// ===== rtl/tag_dedup_table_with_aging_core.sv =====
// Tag de-duplication table with ageing.
// Input channel in_valid / in_stall / in_data carries one word per item: an
// observation (cmd 0) of a 96-bit tag with the current millisecond time, or
// a sweep (cmd 1) that ages out entries unseen for over ten timeouts.
// Output channel out_valid / out_stall / out_data returns exactly one word
// per item: report, table_full, removed_count and occupancy.
// The timeout register is written through cfg_valid / cfg_ready / cfg_data,
// always ready. The user must write it only while no item is in flight;
// the block itself does not enforce this.
// Processing: for each item the table engine takes the task, does one read
// per slot of the single-port entry memory, checks the last slot and closes
// the scan, then registers the result word. It takes a new item only after
// the last one is done. A two-word queue lets the input keep accepting while
// the engine works.
// Reset empties the table, clears the queue and out_valid and loads
// the timeout with 1000 ms. While the receiver stalls, the result word
// holds; the engine then stops at the end of its next item and the queue
// fills, after which in_stall rises.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tag_dedup_table_with_aging_core
// Top level: front, task queue and table engine.
// ----------------------------------------------------------------------------
module tag_dedup_table_with_aging_core #(
  parameter int unsigned TABLE_DEPTH = tdt_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [tdt_pkg::TIMEOUT_W-1:0] cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire tdt_pkg::in_word_t             in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output tdt_pkg::out_word_t                 out_data
);
  import tdt_pkg::*;

  q_status_t q_status;
  task_t     push_task;
  task_t     pop_task;
  logic      q_push;
  logic      q_pop;

  tdt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_status  (q_status),
    .q_push    (q_push),
    .q_task    (push_task)
  );

  tdt_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_task),
    .pop       (q_pop),
    .pop_data  (pop_task),
    .status    (q_status)
  );

  tdt_engine #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .q_task    (pop_task),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTH
  a_pop_not_empty : assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_status.empty)
    else $error("task popped from empty queue");

  a_full_reports : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.table_full |-> out_data.report)
    else $error("full table word without report");

  a_full_occupancy : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.table_full |-> out_data.occupancy == 5'(TABLE_DEPTH))
    else $error("full table word with table not full");

  a_sweep_quiet : assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.removed_count != '0) |->
      !out_data.report && !out_data.table_full)
    else $error("sweep word carries observation flags");
`endif

endmodule : tag_dedup_table_with_aging_core
`default_nettype wire

// ===== rtl/tdt_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdt_front
// Input side: holds the timeout register, accepts words and classifies them
// into table tasks with precomputed sweep limit.
// ----------------------------------------------------------------------------
module tdt_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [tdt_pkg::TIMEOUT_W-1:0] cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire tdt_pkg::in_word_t             in_data,
  input  wire tdt_pkg::q_status_t            q_status,
  output logic                               q_push,
  output tdt_pkg::task_t                     q_task
);
  import tdt_pkg::*;

  logic [TIMEOUT_W-1:0] timeout;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      timeout <= cfg_data;
    end
  end

  assign in_stall = q_status.full;
  assign q_push   = in_valid && !q_status.full;

  always_comb begin
    q_task.sweep    = (in_data.cmd == CMD_SWEEP);
    q_task.key_high = in_data.epc_high;
    q_task.key_low  = in_data.epc_low;
    q_task.now      = in_data.now_ms;
    q_task.timeout  = timeout;
    q_task.limit    = LIMIT_W'(timeout) * LIMIT_W'(SWEEP_FACTOR);
  end

endmodule : tdt_front
`default_nettype wire

// ===== rtl/tdt_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdt_fifo
// Short task queue between the front and the table engine.
// ----------------------------------------------------------------------------
module tdt_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire tdt_pkg::task_t push_data,
  input  wire logic           pop,
  output tdt_pkg::task_t      pop_data,
  output tdt_pkg::q_status_t  status
);
  import tdt_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  task_t            slot [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign status.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_data     = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule : tdt_fifo
`default_nettype wire

// ===== rtl/tdt_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdt_engine
// Table engine: scans the entry memory one slot a cycle for each task,
// applies the lookup, store, refresh or ageing and registers the result word.
// ----------------------------------------------------------------------------
module tdt_engine #(
  parameter int unsigned TABLE_DEPTH = tdt_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire tdt_pkg::q_status_t q_status,
  input  wire tdt_pkg::task_t     q_task,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output tdt_pkg::out_word_t      out_data
);
  import tdt_pkg::*;

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = IDX_W + 1;
  localparam int unsigned OCC_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  typedef struct packed {
    logic [31:0] key_high;
    logic [63:0] key_low;
    logic [31:0] seen_ms;
  } entry_t;

  state_t           state;
  task_t            cur;
  entry_t           mem [TABLE_DEPTH];
  entry_t           rd_data;
  entry_t           wr_data;
  logic             valid [TABLE_DEPTH];
  logic [CNT_W-1:0] ra;
  logic             rd_en;
  logic             chk_en;
  logic [IDX_W-1:0] chk_idx;
  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic             due;
  logic             free;
  logic [IDX_W-1:0] free_idx;
  logic [OCC_W-1:0] removed;
  logic [OCC_W-1:0] occ;
  logic [OCC_W-1:0] occ_next;
  logic             fin_go;
  logic             store;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic [31:0]      age;
  logic             key_eq;
  logic             chk_valid;
  logic [31:0]      occ_ext;
  logic [31:0]      rem_ext;
  out_word_t        result;

  assign rd_en     = (state == ST_SCAN) && (ra < CNT_W'(TABLE_DEPTH));
  assign q_pop     = (state == ST_IDLE) && !q_status.empty;
  assign fin_go    = (state == ST_FIN) && (!out_valid || !out_stall);
  assign store     = !cur.sweep && !hit && free;
  assign wr_en     = fin_go && !cur.sweep && (hit || free);
  assign wr_idx    = hit ? hit_idx : free_idx;
  assign age       = cur.now - rd_data.seen_ms;
  assign key_eq    = (rd_data.key_high == cur.key_high) && (rd_data.key_low == cur.key_low);
  assign chk_valid = valid[chk_idx];
  assign occ_next  = store ? occ + 1'b1 : occ;
  assign occ_ext   = 32'(occ_next);
  assign rem_ext   = 32'(removed);

  always_comb begin
    wr_data.key_high  = cur.key_high;
    wr_data.key_low   = cur.key_low;
    wr_data.seen_ms   = cur.now;
    result.report        = !cur.sweep && (hit ? due : 1'b1);
    result.table_full    = !cur.sweep && !hit && !free;
    result.removed_count = rem_ext[4:0];
    result.occupancy     = occ_ext[4:0];
  end

  // entry memory
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[ra[IDX_W-1:0]];
    end
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      chk_idx <= ra[IDX_W-1:0];
    end
    if (q_pop) begin
      cur <= q_task;
    end
    if (fin_go) begin
      out_data <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      chk_en    <= 1'b0;
      occ       <= '0;
      out_valid <= 1'b0;
      ra        <= '0;
      hit       <= 1'b0;
      free      <= 1'b0;
      removed   <= '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        valid[i] <= 1'b0;
      end
    end else begin
      chk_en <= rd_en;
      if (fin_go) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_pop) begin
            ra      <= '0;
            hit     <= 1'b0;
            free    <= 1'b0;
            removed <= '0;
            state   <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (rd_en) begin
            ra <= ra + 1'b1;
          end
          if (chk_en) begin
            if (cur.sweep) begin
              if (chk_valid && ({1'b0, age} > cur.limit)) begin
                valid[chk_idx] <= 1'b0;
                removed        <= removed + 1'b1;
                occ            <= occ - 1'b1;
              end
            end else if (!hit) begin
              if (chk_valid && key_eq) begin
                hit     <= 1'b1;
                hit_idx <= chk_idx;
                due     <= (age >= {3'b000, cur.timeout});
              end else if (!chk_valid && !free) begin
                free     <= 1'b1;
                free_idx <= chk_idx;
              end
            end
          end
          if (!rd_en && !chk_en) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (fin_go) begin
            occ <= occ_next;
            if (store) begin
              valid[free_idx] <= 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule : tdt_engine
`default_nettype wire
